[rtl/nsry_pkg.sv]
// Shared types and constants of the nearest-neighbor scaler with RGBA to YUVA conversion.
`default_nettype none

package nsry_pkg;

    localparam int SRC_PIXELS  = 65536;
    localparam int ADDR_W      = $clog2(SRC_PIXELS);
    localparam int MAX_DST_DIM = 4096;

    localparam int SW_W   = 9;
    localparam int DW_W   = 13;
    localparam int DX_W   = 12;
    localparam int NUM_W  = DX_W + SW_W;
    localparam int Q_W    = SW_W;
    localparam int ROW_W  = 2 * SW_W;
    localparam int CFG_W  = DW_W;
    localparam int IDX_W  = 16;

    localparam int PROD_W = 26;
    localparam int SUM_W  = 28;

    localparam int Y_R = 19595;
    localparam int Y_G = 38470;
    localparam int Y_B = 7471;
    localparam int U_R = -11058;
    localparam int U_G = -21710;
    localparam int U_B = 32768;
    localparam int V_R = 32768;
    localparam int V_G = -27439;
    localparam int V_B = -5329;
    localparam int CHROMA_OFS = 128 << 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

endpackage

`default_nettype wire

[rtl/nsry_req_if.sv]
// Request channel: load and read transactions into the scaler.
`default_nettype none

interface nsry_req_if
    import nsry_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            op;
    logic [IDX_W-1:0] load_index;
    logic [7:0]      red_in;
    logic [7:0]      green_in;
    logic [7:0]      blue_in;
    logic [7:0]      alpha_in;
    logic [DX_W-1:0] dst_x;
    logic [DX_W-1:0] dst_y;

    modport source (
        output valid, op, load_index, red_in, green_in, blue_in, alpha_in, dst_x, dst_y,
        input  ready
    );

    modport sink (
        input  valid, op, load_index, red_in, green_in, blue_in, alpha_in, dst_x, dst_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/nsry_rsp_if.sv]
// Response channel: YUVA results out of the scaler.
`default_nettype none

interface nsry_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] alpha_out;

    modport source (
        output valid, luma, chroma_u, chroma_v, alpha_out,
        input  ready
    );

    modport sink (
        input  valid, luma, chroma_u, chroma_v, alpha_out,
        output ready
    );
endinterface

`default_nettype wire

[rtl/nearest_scale_rgba_to_yuva.sv]
// Top level: nearest-neighbor scaler with source image store and RGB to YUV conversion.
//
//  channel   dir   contents
//  req       in    op, load_index, red/green/blue/alpha_in, dst_x, dst_y
//  rsp       out   luma, chroma_u, chroma_v, alpha_out (read ops only)
//  cfg_*     in    src_width, src_height, dst_width, dst_height
//
// One transaction per cycle while rsp is not stalled; a read result is registered in
// the input, 9-step restoring divider, clamp, row, address, store and color stages.
// Loads write the store in program order at the same stage where reads fetch.
// Reset only clears valid bits and sets config registers to 1; the store is not cleared.
// A stall on rsp freezes every stage; nothing is lost or repeated.
`default_nettype none

module nearest_scale_rgba_to_yuva
    import nsry_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    nsry_req_if.sink              req,
    nsry_rsp_if.source            rsp,
    input  wire logic             cfg_wen,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int DIV_STEPS = Q_W;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        pixel_t           pixel;
        logic [DX_W-1:0]  dx;
        logic [DX_W-1:0]  dy;
    } in_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        pixel_t           pixel;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
        logic             ovf_x;
        logic             ovf_y;
    } div_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        pixel_t           pixel;
        logic [SW_W-1:0]  sx;
        logic [SW_W-1:0]  sy;
    } clp_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        pixel_t           pixel;
        logic [SW_W-1:0]  sx;
        logic [ROW_W-1:0] row_base;
    } row_t;

    typedef struct packed {
        op_t               op;
        pixel_t            pixel;
        logic [ADDR_W-1:0] addr;
    } adr_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic [7:0] alpha_out;
    } out_t;

    function automatic logic [7:0] q16_to_byte(input logic signed [SUM_W-1:0] s);
        logic [7:0] res;
        if (s < 0)
            res = 8'd0;
        else if (s[SUM_W-2:24] != '0)
            res = 8'hFF;
        else
            res = s[23:16];
        return res;
    endfunction

    // configuration
    logic [SW_W-1:0] cfg_src_w_reg, cfg_src_h_reg;
    logic [DW_W-1:0] cfg_dst_w_reg, cfg_dst_h_reg;
    logic [SW_W-1:0] src_w, src_h;
    logic [DW_W-1:0] dst_w, dst_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_src_w_reg <= SW_W'(1);
            cfg_src_h_reg <= SW_W'(1);
            cfg_dst_w_reg <= DW_W'(1);
            cfg_dst_h_reg <= DW_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:  cfg_src_w_reg <= cfg_data[SW_W-1:0];
                REG_SRC_HEIGHT: cfg_src_h_reg <= cfg_data[SW_W-1:0];
                REG_DST_WIDTH:  cfg_dst_w_reg <= cfg_data[DW_W-1:0];
                REG_DST_HEIGHT: cfg_dst_h_reg <= cfg_data[DW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        src_w = (cfg_src_w_reg == '0) ? SW_W'(1) : cfg_src_w_reg;
        src_h = (cfg_src_h_reg == '0) ? SW_W'(1) : cfg_src_h_reg;
        if (cfg_dst_w_reg == '0)
            dst_w = DW_W'(1);
        else if (cfg_dst_w_reg > DW_W'(MAX_DST_DIM))
            dst_w = DW_W'(MAX_DST_DIM);
        else
            dst_w = cfg_dst_w_reg;
        if (cfg_dst_h_reg == '0)
            dst_h = DW_W'(1);
        else if (cfg_dst_h_reg > DW_W'(MAX_DST_DIM))
            dst_h = DW_W'(MAX_DST_DIM);
        else
            dst_h = cfg_dst_h_reg;
    end

    // pipeline control
    logic adv;
    logic out_valid_reg;
    out_t out_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    logic                     v_in_reg;
    in_t                      in_reg;
    logic                     v_div_reg [0:DIV_STEPS];
    div_t                     div_reg   [0:DIV_STEPS];
    div_t                     div_next  [0:DIV_STEPS];
    logic                     v_clp_reg;
    clp_t                     clp_reg, clp_next;
    logic                     v_row_reg;
    row_t                     row_reg, row_next;
    logic                     v_adr_reg;
    adr_t                     adr_reg, adr_next;
    logic                     v_mem_reg;
    pixel_t                   rd_reg;
    logic                     v_prd_reg;
    logic signed [PROD_W-1:0] py_reg [0:2];
    logic signed [PROD_W-1:0] pu_reg [0:2];
    logic signed [PROD_W-1:0] pv_reg [0:2];
    logic [7:0]               pa_reg;
    out_t                     out_next;

    pixel_t mem [0:SRC_PIXELS-1];

    // mapping multiply and divider steps
    always_comb
    begin
        div_t           cur;
        logic [NUM_W:0] dx_sh;
        logic [NUM_W:0] dy_sh;
        div_next[0].op    = in_reg.op;
        div_next[0].index = in_reg.index;
        div_next[0].pixel = in_reg.pixel;
        div_next[0].rem_x = NUM_W'(in_reg.dx) * NUM_W'(src_w);
        div_next[0].rem_y = NUM_W'(in_reg.dy) * NUM_W'(src_h);
        div_next[0].q_x   = '0;
        div_next[0].q_y   = '0;
        div_next[0].ovf_x = {1'b0, in_reg.dx} >= dst_w;
        div_next[0].ovf_y = {1'b0, in_reg.dy} >= dst_h;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            cur   = div_reg[k];
            dx_sh = {{(NUM_W + 1 - DW_W){1'b0}}, dst_w} << (DIV_STEPS - 1 - k);
            dy_sh = {{(NUM_W + 1 - DW_W){1'b0}}, dst_h} << (DIV_STEPS - 1 - k);
            if ({1'b0, cur.rem_x} >= dx_sh)
            begin
                cur.rem_x = cur.rem_x - dx_sh[NUM_W-1:0];
                cur.q_x[DIV_STEPS-1-k] = 1'b1;
            end
            if ({1'b0, cur.rem_y} >= dy_sh)
            begin
                cur.rem_y = cur.rem_y - dy_sh[NUM_W-1:0];
                cur.q_y[DIV_STEPS-1-k] = 1'b1;
            end
            div_next[k+1] = cur;
        end
    end

    // clamp, row base, address
    always_comb
    begin
        clp_next.op    = div_reg[DIV_STEPS].op;
        clp_next.index = div_reg[DIV_STEPS].index;
        clp_next.pixel = div_reg[DIV_STEPS].pixel;
        clp_next.sx    = div_reg[DIV_STEPS].ovf_x ? src_w - SW_W'(1) : div_reg[DIV_STEPS].q_x;
        clp_next.sy    = div_reg[DIV_STEPS].ovf_y ? src_h - SW_W'(1) : div_reg[DIV_STEPS].q_y;

        row_next.op       = clp_reg.op;
        row_next.index    = clp_reg.index;
        row_next.pixel    = clp_reg.pixel;
        row_next.sx       = clp_reg.sx;
        row_next.row_base = ROW_W'(clp_reg.sy) * ROW_W'(src_w);

        adr_next.op    = row_reg.op;
        adr_next.pixel = row_reg.pixel;
        if (row_reg.op == OP_LOAD)
            adr_next.addr = ADDR_W'(row_reg.index);
        else
            adr_next.addr = ADDR_W'(row_reg.row_base + ROW_W'(row_reg.sx));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg  <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                v_div_reg[k] <= 1'b0;
            v_clp_reg     <= 1'b0;
            v_row_reg     <= 1'b0;
            v_adr_reg     <= 1'b0;
            v_mem_reg     <= 1'b0;
            v_prd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_in_reg     <= req.valid;
            v_div_reg[0] <= v_in_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
                v_div_reg[k] <= v_div_reg[k-1];
            v_clp_reg     <= v_div_reg[DIV_STEPS];
            v_row_reg     <= v_clp_reg;
            v_adr_reg     <= v_row_reg;
            v_mem_reg     <= v_adr_reg && (adr_reg.op == OP_READ);
            v_prd_reg     <= v_mem_reg;
            out_valid_reg <= v_prd_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg.op    <= op_t'(req.op);
            in_reg.index <= req.load_index;
            in_reg.pixel <= '{a: req.alpha_in, b: req.blue_in, g: req.green_in, r: req.red_in};
            in_reg.dx    <= req.dst_x;
            in_reg.dy    <= req.dst_y;
            for (int k = 0; k <= DIV_STEPS; k++)
                div_reg[k] <= div_next[k];
            clp_reg <= clp_next;
            row_reg <= row_next;
            adr_reg <= adr_next;
        end
    end

    // image store
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (v_adr_reg && (adr_reg.op == OP_LOAD))
                mem[adr_reg.addr] <= adr_reg.pixel;
            rd_reg <= mem[adr_reg.addr];
        end
    end

    // color products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            py_reg[0] <= PROD_W'($signed({1'b0, rd_reg.r}) * Y_R);
            py_reg[1] <= PROD_W'($signed({1'b0, rd_reg.g}) * Y_G);
            py_reg[2] <= PROD_W'($signed({1'b0, rd_reg.b}) * Y_B);
            pu_reg[0] <= PROD_W'($signed({1'b0, rd_reg.r}) * U_R);
            pu_reg[1] <= PROD_W'($signed({1'b0, rd_reg.g}) * U_G);
            pu_reg[2] <= PROD_W'($signed({1'b0, rd_reg.b}) * U_B);
            pv_reg[0] <= PROD_W'($signed({1'b0, rd_reg.r}) * V_R);
            pv_reg[1] <= PROD_W'($signed({1'b0, rd_reg.g}) * V_G);
            pv_reg[2] <= PROD_W'($signed({1'b0, rd_reg.b}) * V_B);
            pa_reg    <= rd_reg.a;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] su;
        logic signed [SUM_W-1:0] sv;
        sy = SUM_W'(py_reg[0]) + SUM_W'(py_reg[1]) + SUM_W'(py_reg[2]);
        su = SUM_W'(pu_reg[0]) + SUM_W'(pu_reg[1]) + SUM_W'(pu_reg[2])
           + SUM_W'(CHROMA_OFS);
        sv = SUM_W'(pv_reg[0]) + SUM_W'(pv_reg[1]) + SUM_W'(pv_reg[2])
           + SUM_W'(CHROMA_OFS);
        out_next.luma      = q16_to_byte(sy);
        out_next.chroma_u  = q16_to_byte(su);
        out_next.chroma_v  = q16_to_byte(sv);
        out_next.alpha_out = pa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_prd_reg)
            out_reg <= out_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.luma      = out_reg.luma;
    assign rsp.chroma_u  = out_reg.chroma_u;
    assign rsp.chroma_v  = out_reg.chroma_v;
    assign rsp.alpha_out = out_reg.alpha_out;

`ifndef SYNTHESIS
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_adr_reg && (adr_reg.op == OP_LOAD)) |=> !v_mem_reg)
        else $error("load transaction produced a fetch");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(v_mem_reg) && $stable(v_prd_reg) && $stable(v_clp_reg)))
        else $error("pipeline moved during stall");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_prd_reg) |=> rsp.valid)
        else $error("finished transaction did not reach output");
`endif

endmodule

`default_nettype wire

[verif/nearest_scale_rgba_to_yuva_test.sv]
// Self-checking testbench for the nearest-neighbor scaler with RGBA to YUVA conversion.
module nearest_scale_rgba_to_yuva_test
    import nsry_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_WORDS     = 65536;
    localparam int DST_LIMIT     = 4096;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 23;
    localparam int PHASE_ITEMS   = 60;

    localparam int CY_R = 19595;
    localparam int CY_G = 38470;
    localparam int CY_B = 7471;
    localparam int CU_R = -11058;
    localparam int CU_G = -21710;
    localparam int CU_B = 32768;
    localparam int CV_R = 32768;
    localparam int CV_G = -27439;
    localparam int CV_B = -5329;
    localparam int C_OFFSET = 128 << 16;

    typedef struct {
        op_t          op;
        logic [15:0]  load_index;
        pixel_t       pix;
        logic [11:0]  dst_x;
        logic [11:0]  dst_y;
    } scaler_txn_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] alpha;
    } yuva_t;

    typedef struct {
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
    } geometry_t;

    class yuva_scoreboard;
        logic [31:0] image_mem [IMG_WORDS];
        bit          written [IMG_WORDS];
        logic [8:0]  src_w;
        logic [8:0]  src_h;
        logic [12:0] dst_w;
        logic [12:0] dst_h;
        yuva_t       expected_q [$];
        int          errors;

        function new();
            src_w  = 1;
            src_h  = 1;
            dst_w  = 1;
            dst_h  = 1;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t which, int unsigned val);
            case (which)
                REG_SRC_WIDTH:  src_w = val[8:0];
                REG_SRC_HEIGHT: src_h = val[8:0];
                REG_DST_WIDTH:  dst_w = val[12:0];
                REG_DST_HEIGHT: dst_h = val[12:0];
                default: ;
            endcase
        endfunction

        function int unsigned src_dim(logic [8:0] v);
            return (v == 0) ? 1 : v;
        endfunction

        function int unsigned dst_dim(logic [12:0] v);
            if (v == 0)
                return 1;
            if (v > DST_LIMIT)
                return DST_LIMIT;
            return v;
        endfunction

        function int unsigned scale_coord(int unsigned d, int unsigned s, int unsigned dd);
            int unsigned q;
            q = (d * s) / dd;
            return (q > s - 1) ? s - 1 : q;
        endfunction

        function logic [15:0] source_addr(logic [11:0] dx, logic [11:0] dy);
            int unsigned sw;
            int unsigned sx;
            int unsigned sy;
            sw = src_dim(src_w);
            sx = scale_coord(dx, sw, dst_dim(dst_w));
            sy = scale_coord(dy, src_dim(src_h), dst_dim(dst_h));
            return 16'((sy * sw + sx) % IMG_WORDS);
        endfunction

        function logic [7:0] q16_byte(int sum);
            if (sum < 0)
                return 8'd0;
            if ((sum >>> 16) > 255)
                return 8'hFF;
            return 8'(sum >>> 16);
        endfunction

        function yuva_t convert(logic [31:0] word);
            pixel_t p;
            int     r;
            int     g;
            int     b;
            yuva_t  res;
            p = pixel_t'(word);
            r = int'(p.r);
            g = int'(p.g);
            b = int'(p.b);
            res.luma  = q16_byte(CY_R * r + CY_G * g + CY_B * b);
            res.u     = q16_byte(CU_R * r + CU_G * g + CU_B * b + C_OFFSET);
            res.v     = q16_byte(CV_R * r + CV_G * g + CV_B * b + C_OFFSET);
            res.alpha = p.a;
            return res;
        endfunction

        function void note_request(scaler_txn_t t);
            yuva_t want;
            if (t.op == OP_LOAD)
            begin
                image_mem[t.load_index] = t.pix;
                written[t.load_index]   = 1'b1;
            end
            else
            begin
                want       = convert(image_mem[source_addr(t.dst_x, t.dst_y)]);
                expected_q = {expected_q, want};
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s mismatch: got %h want %h", name, got, want));
        endtask

        task check_result(yuva_t got);
            yuva_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no pending read: %h", got));
                return;
            end
            want = expected_q.pop_front();
            compare_field("luma", got.luma, want.luma);
            compare_field("chroma_u", got.u, want.u);
            compare_field("chroma_v", got.v, want.v);
            compare_field("alpha_out", got.alpha, want.alpha);
        endtask
    endclass

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_wen = 1'b0;
    cfg_reg_t         cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    bit               no_gaps = 1'b0;
    bit               draining = 1'b0;
    bit               hold_req = 1'b0;
    yuva_scoreboard   sb = new();

    nsry_req_if req ();
    nsry_rsp_if rsp ();

    nearest_scale_rgba_to_yuva dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp.ready <= 1'b0;
            end
            else if (draining || no_gaps)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            sb.check_result(yuva_t'{rsp.luma, rsp.chroma_u, rsp.chroma_v, rsp.alpha_out});
    end

    task automatic send_txn(scaler_txn_t t);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= t.op;
        req.load_index <= t.load_index;
        req.red_in     <= t.pix.r;
        req.green_in   <= t.pix.g;
        req.blue_in    <= t.pix.b;
        req.alpha_in   <= t.pix.a;
        req.dst_x      <= t.dst_x;
        req.dst_y      <= t.dst_y;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(t);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, int unsigned val);
        cfg_wen   <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        sb.write_reg(which, val);
        @(negedge clk);
    endtask

    task automatic set_geometry(geometry_t g);
        write_reg(REG_SRC_WIDTH, g.sw);
        write_reg(REG_SRC_HEIGHT, g.sh);
        write_reg(REG_DST_WIDTH, g.dw);
        write_reg(REG_DST_HEIGHT, g.dh);
        cfg_wen <= 1'b0;
    endtask

    // loads may still be in flight once the last read result is out
    task automatic wait_drained();
        req.valid <= 1'b0;
        draining = 1'b1;
        for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        draining = 1'b0;
    endtask

    function automatic pixel_t random_pixel();
        case ($urandom_range(9))
            0: return pixel_t'(32'h00000000);
            1: return pixel_t'(32'hFFFFFFFF);
            2: return pixel_t'(32'hFF0000FF);
            3: return pixel_t'(32'h00FF0000);
            4: return pixel_t'(32'h0000FF00);
            default: return pixel_t'($urandom);
        endcase
    endfunction

    function automatic scaler_txn_t make_load(logic [15:0] idx, pixel_t p);
        scaler_txn_t t;
        t.op         = OP_LOAD;
        t.load_index = idx;
        t.pix        = p;
        t.dst_x      = 12'($urandom_range(4095));
        t.dst_y      = 12'($urandom_range(4095));
        return t;
    endfunction

    function automatic scaler_txn_t make_read(logic [11:0] dx, logic [11:0] dy);
        scaler_txn_t t;
        t.op         = OP_READ;
        t.load_index = 16'($urandom_range(65535));
        t.pix        = pixel_t'($urandom);
        t.dst_x      = dx;
        t.dst_y      = dy;
        return t;
    endfunction

    function automatic logic [11:0] pick_coord(int unsigned dim);
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'(dim - 1);
            2: return 12'(dim);
            3: return 12'hFFF;
            4: return 12'($urandom_range(4095));
            default: return 12'($urandom_range(dim - 1));
        endcase
    endfunction

    task automatic random_phase(int count);
        int          sel;
        int unsigned region;
        logic [11:0] dx;
        logic [11:0] dy;
        logic [15:0] addr;
        for (int i = 0; i < count; i++)
        begin
            sel    = $urandom_range(99);
            region = sb.src_dim(sb.src_w) * sb.src_dim(sb.src_h);
            if (region > IMG_WORDS)
                region = IMG_WORDS;
            if (sel < 10)
                send_txn(make_load(16'($urandom_range(65535)), random_pixel()));
            else if (sel < 35)
                send_txn(make_load(16'($urandom_range(region - 1)), random_pixel()));
            else
            begin
                dx   = pick_coord(sb.dst_dim(sb.dst_w));
                dy   = pick_coord(sb.dst_dim(sb.dst_h));
                addr = sb.source_addr(dx, dy);
                if (!sb.written[addr])
                    send_txn(make_load(addr, random_pixel()));
                send_txn(make_read(dx, dy));
            end
        end
    endtask

    task automatic directed_swatches();
        logic [31:0] swatch [12] = '{
            32'h00000000, 32'hFFFFFFFF, 32'hFF0000FF, 32'h8000FF00,
            32'h40FF0000, 32'hFFFFFF00, 32'hFFFF00FF, 32'hFF00FFFF,
            32'h7F808080, 32'h01010101, 32'hFEFEFEFE, 32'hA5123456
        };
        geometry_t g;
        g = '{4, 3, 8, 6};
        set_geometry(g);
        for (int i = 0; i < 12; i++)
            send_txn(make_load(16'(i), pixel_t'(swatch[i])));
        // 2x upscale: each source pixel once, then a far corner that clamps
        for (int i = 0; i < 12; i++)
            send_txn(make_read(12'(2 * (i % 4) + (i % 2)), 12'(2 * (i / 4) + (i % 2))));
        send_txn(make_read(12'hFFF, 12'hFFF));
        wait_drained();
    endtask

    initial
    begin
        geometry_t plan [8];
        geometry_t g;
        req.valid      = 1'b0;
        req.op         = OP_LOAD;
        req.load_index = '0;
        req.red_in     = '0;
        req.green_in   = '0;
        req.blue_in    = '0;
        req.alpha_in   = '0;
        req.dst_x      = '0;
        req.dst_y      = '0;
        plan = '{
            '{1, 1, 1, 1},
            '{0, 0, 0, 0},
            '{256, 256, 4096, 4096},
            '{256, 256, 8191, 8191},
            '{7, 5, 13, 9},
            '{64, 48, 16, 12},
            '{511, 300, 100, 8191},
            '{16, 16, 4096, 1}
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_swatches();
        for (int p = 0; p < 12; p++)
        begin
            if (p < 8)
                g = plan[p];
            else
                g = '{$urandom_range(1, 40), $urandom_range(1, 40),
                      $urandom_range(1, 200), $urandom_range(1, 200)};
            set_geometry(g);
            if (p == 2)
                hold_req = 1'b1;
            no_gaps = (p == 4);
            if (p == 6)
            begin
                random_phase(PHASE_ITEMS / 2);
                wait_drained();
                random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                random_phase(PHASE_ITEMS);
            no_gaps = 1'b0;
            wait_drained();
        end
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[nearest_scale_rgba_to_yuva.f]
rtl/nsry_pkg.sv
rtl/nsry_req_if.sv
rtl/nsry_rsp_if.sv
rtl/nearest_scale_rgba_to_yuva.sv
verif/nearest_scale_rgba_to_yuva_test.sv
